// ===== sv/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Default sizes, datapath select codes and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Memory read address sources
  typedef enum logic [2:0] {
    RD_NODE = 3'd0,
    RD_LC   = 3'd1,
    RD_RC   = 3'd2,
    RD_ROOT = 3'd3,
    RD_KM1  = 3'd4,
    RD_K    = 3'd5
  } rd_sel_t;

  // Memory write sources during the sort
  typedef enum logic [2:0] {
    WR_NONE = 3'd0,
    WR_NODE = 3'd1,   // mem[node]    <= big_val
    WR_BIG  = 3'd2,   // mem[big_idx] <= node_val
    WR_ROOT = 3'd3,   // mem[0]       <= read data
    WR_KM1  = 3'd4    // mem[k-1]     <= node_val
  } wr_sel_t;

  typedef struct packed {
    logic    load;          // store an accepted request at the fill count
    logic    clear_run;     // end of run: drop count and overflow flag
    logic    k_init_half;   // k <= count / 2
    logic    k_init_full;   // k <= count
    logic    k_dec;
    logic    k_clr;
    logic    k_inc;
    logic    sift_build;    // node <= k-1, heap length <= count
    logic    sift_extract;  // node <= 0,   heap length <= k-1
    logic    cap_node;      // node_val/big_val <= read data, big_idx <= node
    logic    cap_lc;        // keep left child if larger
    logic    cap_rc;        // keep right child if larger
    logic    node_step;     // node <= big_idx
    logic    out_load;      // load the result register
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } hse_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_le1;
    logic lc_in;     // left child inside the heap
    logic rc_in;     // right child inside the heap
    logic at_node;   // largest of the three is the node itself
    logic out_last;  // result register holds the final element
  } hse_stat_t;

endpackage

// ===== sv/hse_dp.sv =====
// ----------------------------------------------------------------------------
// hse_dp: heap sort datapath
// Element memory with one write and one registered read port, the index and
// value registers of the sift unit, fill count, overflow flag and the result
// register.
// ----------------------------------------------------------------------------
module hse_dp #(
  parameter int MAX_ITEMS  = hse_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = hse_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hse_pkg::hse_cmd_t            cmd,
  output hse_pkg::hse_stat_t           stat,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic signed [VALUE_BITS-1:0] sorted_value,
  output logic                         last_result,
  output logic                         overflow
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int LW = IW + 2;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] node_val;
  logic [VALUE_BITS-1:0] big_val;
  logic [IW-1:0]         node;
  logic [IW-1:0]         big_idx;
  logic [CW-1:0]         count;
  logic [CW-1:0]         k;
  logic [CW-1:0]         heap_len;
  logic                  ovf_seen;

  logic [LW-1:0]         lc;
  logic [LW-1:0]         rc;
  logic [LW-1:0]         len_ext;
  logic [CW-1:0]         km1;
  logic                  full;
  logic                  gt;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  we;

  // Child indexes and heap bounds
  assign lc      = {1'b0, node, 1'b1};
  assign rc      = LW'(lc + LW'(1));
  assign len_ext = LW'(heap_len);
  assign km1     = CW'(k - CW'(1));
  assign full    = (count == CW'(MAX_ITEMS));
  assign gt      = $signed(rdata) > $signed(big_val);

  assign stat.k_zero   = (k == '0);
  assign stat.k_le1    = (k <= CW'(1));
  assign stat.lc_in    = (lc < len_ext);
  assign stat.rc_in    = (rc < len_ext);
  assign stat.at_node  = (big_idx == node);
  assign stat.out_last = last_result;

  // Select read address
  always_comb begin
    case (cmd.rd_sel)
      hse_pkg::RD_NODE: raddr = node;
      hse_pkg::RD_LC:   raddr = lc[IW-1:0];
      hse_pkg::RD_RC:   raddr = rc[IW-1:0];
      hse_pkg::RD_ROOT: raddr = '0;
      hse_pkg::RD_KM1:  raddr = km1[IW-1:0];
      hse_pkg::RD_K:    raddr = k[IW-1:0];
      default:          raddr = node;
    endcase
  end

  // Select write port; loading and sorting never overlap
  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = big_val;
    if (cmd.load) begin
      we    = !full;
      waddr = count[IW-1:0];
      wdata = value;
    end else begin
      case (cmd.wr_sel)
        hse_pkg::WR_NONE: we = 1'b0;
        hse_pkg::WR_NODE: begin
          we    = 1'b1;
          waddr = node;
          wdata = big_val;
        end
        hse_pkg::WR_BIG: begin
          we    = 1'b1;
          waddr = big_idx;
          wdata = node_val;
        end
        hse_pkg::WR_ROOT: begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata;
        end
        hse_pkg::WR_KM1: begin
          we    = 1'b1;
          waddr = km1[IW-1:0];
          wdata = node_val;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // Element memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.clear_run) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_seen <= 1'b1;
      end else begin
        count <= CW'(count + CW'(1));
      end
    end
  end

  // Loop counter
  always_ff @(posedge clk) begin
    if (cmd.k_init_half) begin
      k <= count >> 1;
    end else if (cmd.k_init_full) begin
      k <= count;
    end else if (cmd.k_dec) begin
      k <= km1;
    end else if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= CW'(k + CW'(1));
    end
  end

  // Sift registers
  always_ff @(posedge clk) begin
    if (cmd.sift_build) begin
      node     <= km1[IW-1:0];
      heap_len <= count;
    end else if (cmd.sift_extract) begin
      node     <= '0;
      heap_len <= km1;
    end else if (cmd.node_step) begin
      node <= big_idx;
    end
    if (cmd.cap_node) begin
      node_val <= rdata;
      big_val  <= rdata;
      big_idx  <= node;
    end else if (cmd.cap_lc && gt) begin
      big_val <= rdata;
      big_idx <= lc[IW-1:0];
    end else if (cmd.cap_rc && gt) begin
      big_val <= rdata;
      big_idx <= rc[IW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sorted_value <= rdata;
      last_result  <= (CW'(k + CW'(1)) == count);
      overflow     <= ovf_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_ovf_on_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf_seen) |-> $past(count) == CW'(MAX_ITEMS))
    else $error("overflow flag set while store had room");

  a_lc_read_in_heap: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_sel == hse_pkg::RD_LC) |-> stat.lc_in)
    else $error("left child read outside heap");

endmodule

// ===== sv/hse_ctrl.sv =====
// ----------------------------------------------------------------------------
// hse_ctrl: heap sort controller
// Sequences loading, heap build, root extraction with sift down, and the
// ascending readout with its output handshake.
// ----------------------------------------------------------------------------
module hse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last_item,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output hse_pkg::hse_cmd_t   cmd,
  input  hse_pkg::hse_stat_t  stat
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_BLD_INIT = 17'h00002,
    S_BLD_NEXT = 17'h00004,
    S_SF_RN    = 17'h00008,
    S_SF_RL    = 17'h00010,
    S_SF_CL    = 17'h00020,
    S_SF_CR    = 17'h00040,
    S_SF_SW    = 17'h00080,
    S_SF_SW2   = 17'h00100,
    S_XT_CHECK = 17'h00200,
    S_XT_R0    = 17'h00400,
    S_XT_R1    = 17'h00800,
    S_XT_W0    = 17'h01000,
    S_XT_W1    = 17'h02000,
    S_OUT_RD   = 17'h04000,
    S_OUT_LD   = 17'h08000,
    S_OUT_HOLD = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   build_phase;
  logic   build_phase_next;
  state_t sift_exit;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT_HOLD);

  // Where a finished sift returns to
  assign sift_exit = build_phase ? S_BLD_NEXT : S_XT_CHECK;

  // Next state and commands
  always_comb begin
    state_next       = state;
    build_phase_next = build_phase;
    cmd              = '0;
    cmd.rd_sel       = hse_pkg::RD_NODE;
    cmd.wr_sel       = hse_pkg::WR_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_item) begin
            state_next = S_BLD_INIT;
          end
        end
      end
      S_BLD_INIT: begin
        cmd.k_init_half = 1'b1;
        state_next      = S_BLD_NEXT;
      end
      S_BLD_NEXT: begin
        if (stat.k_zero) begin
          cmd.k_init_full = 1'b1;
          state_next      = S_XT_CHECK;
        end else begin
          cmd.sift_build   = 1'b1;
          build_phase_next = 1'b1;
          state_next       = S_SF_RN;
        end
      end
      S_SF_RN: begin
        cmd.rd_sel = hse_pkg::RD_NODE;
        state_next = S_SF_RL;
      end
      S_SF_RL: begin
        cmd.cap_node = 1'b1;
        if (stat.lc_in) begin
          cmd.rd_sel = hse_pkg::RD_LC;
          state_next = S_SF_CL;
        end else begin
          cmd.k_dec  = 1'b1;
          state_next = sift_exit;
        end
      end
      S_SF_CL: begin
        cmd.cap_lc = 1'b1;
        if (stat.rc_in) begin
          cmd.rd_sel = hse_pkg::RD_RC;
          state_next = S_SF_CR;
        end else begin
          state_next = S_SF_SW;
        end
      end
      S_SF_CR: begin
        cmd.cap_rc = 1'b1;
        state_next = S_SF_SW;
      end
      S_SF_SW: begin
        if (stat.at_node) begin
          cmd.k_dec  = 1'b1;
          state_next = sift_exit;
        end else begin
          cmd.wr_sel = hse_pkg::WR_NODE;
          state_next = S_SF_SW2;
        end
      end
      S_SF_SW2: begin
        cmd.wr_sel    = hse_pkg::WR_BIG;
        cmd.node_step = 1'b1;
        state_next    = S_SF_RN;
      end
      S_XT_CHECK: begin
        if (stat.k_le1) begin
          cmd.k_clr  = 1'b1;
          state_next = S_OUT_RD;
        end else begin
          state_next = S_XT_R0;
        end
      end
      S_XT_R0: begin
        cmd.rd_sel = hse_pkg::RD_ROOT;
        state_next = S_XT_R1;
      end
      S_XT_R1: begin
        cmd.cap_node = 1'b1;
        cmd.rd_sel   = hse_pkg::RD_KM1;
        state_next   = S_XT_W0;
      end
      S_XT_W0: begin
        cmd.wr_sel = hse_pkg::WR_ROOT;
        state_next = S_XT_W1;
      end
      S_XT_W1: begin
        cmd.wr_sel       = hse_pkg::WR_KM1;
        cmd.sift_extract = 1'b1;
        build_phase_next = 1'b0;
        state_next       = S_SF_RN;
      end
      S_OUT_RD: begin
        cmd.rd_sel = hse_pkg::RD_K;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready) begin
          if (stat.out_last) begin
            cmd.clear_run = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      build_phase <= 1'b0;
    end else begin
      state       <= state_next;
      build_phase <= build_phase_next;
    end
  end

  a_last_starts_build: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_item) |=> (state == S_BLD_INIT))
    else $error("last request did not start the sort");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("loading and readout overlap");

endmodule

// ===== sv/heap_sort_engine_unit.sv =====
// Timing: loading takes one request per cycle while idle; after the last request
// the sort reads the node and its children through the one memory read port
// and writes each swap back with two writes per sift level; then each result is
// read, loaded into the result register and held until out_ready.
// Throughput: one run at a time; no requests are taken during sort or readout.
// Reset (rst, synchronous): controller idle, fill count and overflow cleared;
// the element memory is not cleared.
// ----------------------------------------------------------------------------
// heap_sort_engine_unit: heapsort engine, max-heap, ascending output
// Stores a list of signed values, sorts it in place with heapsort and streams
// the values out in ascending order with last and overflow marks.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit #(
  parameter int MAX_ITEMS  = hse_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = hse_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] sorted_value,
  output logic                         last_result,
  output logic                         overflow
);

  hse_pkg::hse_cmd_t  cmd;
  hse_pkg::hse_stat_t stat;

  // Sequencer
  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_item (last_item),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Memory and sift datapath
  hse_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflow     (overflow)
  );

endmodule
